[hdl/uvcpk_pkg.sv]
// ----------------------------------------------------------------------------
// uvcpk_pkg
// Shared constants for the UVC payload packetizer: register map, reset
// values, header codes and parameter defaults.
// ----------------------------------------------------------------------------
package uvcpk_pkg;

  localparam int POSITION_BITS_DEF     = 23;
  localparam int PACKET_COUNT_BITS_DEF = 12;

  localparam int FRAME_BYTES_W  = 24;
  localparam int PACKET_BYTES_W = 12;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BYTES  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PACKET_BYTES = 1'd1;

  localparam logic [FRAME_BYTES_W-1:0]  FRAME_BYTES_RST  = 24'd614400;
  localparam logic [PACKET_BYTES_W-1:0] PACKET_BYTES_RST = 12'd1024;

  localparam logic [PACKET_BYTES_W-1:0] MIN_PACKET = 12'd3;
  localparam logic [PACKET_BYTES_W-1:0] MAX_PACKET = 12'hC00;

  localparam logic [7:0] HDR_LEN  = 8'h02;
  localparam logic [7:0] FLAG_EOH = 8'h80;
  localparam logic [7:0] FLAG_EOF = 8'h02;

endpackage

[hdl/uvcpk_if.sv]
// ----------------------------------------------------------------------------
// uvcpk_in_if / uvcpk_out_if
// Valid/ready channels for pixel bytes in and packet bytes out.
// ----------------------------------------------------------------------------
interface uvcpk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

interface uvcpk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       packet_end;
  logic       frame_end;

  modport source (output valid, output out_byte, output is_header,
                  output packet_end, output frame_end, input ready);
  modport sink (input valid, input out_byte, input is_header,
                input packet_end, input frame_end, output ready);
endinterface

[hdl/uvc_payload_packetizer.sv]
// ----------------------------------------------------------------------------
// uvc_payload_packetizer
// Cuts a stream of video frame bytes into UVC payload packets. Each packet
// starts with a two-byte header (length 2, then flags: end of header, end of
// frame when the packet holds the frame's last byte, and the frame-ID bit,
// which toggles every frame). A data byte that continues an open packet
// goes straight out; a data byte that opens a packet waits in the held input
// register while both header bytes are issued through the single output
// register ahead of it. The output register lets the next request be taken
// while a result waits downstream.
// ----------------------------------------------------------------------------
module uvc_payload_packetizer #(
  parameter int POSITION_BITS     = uvcpk_pkg::POSITION_BITS_DEF,
  parameter int PACKET_COUNT_BITS = uvcpk_pkg::PACKET_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [uvcpk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [uvcpk_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  uvcpk_in_if.sink                          in_ch,
  uvcpk_out_if.source                       out_ch
);
  import uvcpk_pkg::*;

  logic [POSITION_BITS:0]       frame_len;
  logic [PACKET_COUNT_BITS-1:0] capacity;

  uvcpk_cfg #(
    .POSITION_BITS     (POSITION_BITS),
    .PACKET_COUNT_BITS (PACKET_COUNT_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .frame_len   (frame_len),
    .capacity    (capacity)
  );

  uvcpk_core #(
    .POSITION_BITS     (POSITION_BITS),
    .PACKET_COUNT_BITS (PACKET_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_len (frame_len),
    .capacity  (capacity),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

[hdl/uvcpk_cfg.sv]
// ----------------------------------------------------------------------------
// uvcpk_cfg
// Configuration registers with registered, clamped frame length and packet
// data capacity.
// ----------------------------------------------------------------------------
module uvcpk_cfg #(
  parameter int POSITION_BITS     = uvcpk_pkg::POSITION_BITS_DEF,
  parameter int PACKET_COUNT_BITS = uvcpk_pkg::PACKET_COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [uvcpk_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [uvcpk_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  output logic [POSITION_BITS:0]               frame_len,
  output logic [PACKET_COUNT_BITS-1:0]         capacity
);
  import uvcpk_pkg::*;

  localparam int FW = (POSITION_BITS + 1 > FRAME_BYTES_W) ? POSITION_BITS + 1 : FRAME_BYTES_W;
  localparam int CW = (PACKET_COUNT_BITS > PACKET_BYTES_W) ? PACKET_COUNT_BITS : PACKET_BYTES_W;

  logic [FRAME_BYTES_W-1:0]     frame_bytes_r;
  logic [PACKET_BYTES_W-1:0]    packet_bytes_r;
  logic [POSITION_BITS:0]       frame_len_r, frame_len_nxt;
  logic [PACKET_COUNT_BITS-1:0] capacity_r, capacity_nxt;

  logic [FW-1:0]             f_ext, f_lim, f_clamp;
  logic [PACKET_BYTES_W-1:0] p_clamp, c_raw;
  logic [CW-1:0]             c_ext, c_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r  <= FRAME_BYTES_RST;
      packet_bytes_r <= PACKET_BYTES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_BYTES:  frame_bytes_r  <= cfg_wr_data[FRAME_BYTES_W-1:0];
        REG_PACKET_BYTES: packet_bytes_r <= cfg_wr_data[PACKET_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    f_ext = FW'(frame_bytes_r);
    f_lim = FW'(1) << POSITION_BITS;
    if (f_ext == '0) begin
      f_clamp = FW'(1);
    end else if (f_ext > f_lim) begin
      f_clamp = f_lim;
    end else begin
      f_clamp = f_ext;
    end
    frame_len_nxt = f_clamp[POSITION_BITS:0];

    if (packet_bytes_r < MIN_PACKET) begin
      p_clamp = MIN_PACKET;
    end else if (packet_bytes_r > MAX_PACKET) begin
      p_clamp = MAX_PACKET;
    end else begin
      p_clamp = packet_bytes_r;
    end
    c_raw = p_clamp - PACKET_BYTES_W'(HDR_LEN);
    c_ext = CW'(c_raw);
    c_lim = CW'((CW'(1) << PACKET_COUNT_BITS) - CW'(1));
    capacity_nxt = (c_ext > c_lim) ? c_lim[PACKET_COUNT_BITS-1:0]
                                   : c_ext[PACKET_COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    frame_len_r <= frame_len_nxt;
    capacity_r  <= capacity_nxt;
  end

  assign frame_len = frame_len_r;
  assign capacity  = capacity_r;

endmodule

[hdl/uvcpk_core.sv]
// ----------------------------------------------------------------------------
// uvcpk_core
// Holds one pixel byte, emits the packet header ahead of it when it opens a
// packet, then the data byte; tracks frame position, packet fill and frame ID.
// ----------------------------------------------------------------------------
module uvcpk_core #(
  parameter int POSITION_BITS     = uvcpk_pkg::POSITION_BITS_DEF,
  parameter int PACKET_COUNT_BITS = uvcpk_pkg::PACKET_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [POSITION_BITS:0]       frame_len,
  input  logic [PACKET_COUNT_BITS-1:0] capacity,
  uvcpk_in_if.sink                     in_ch,
  uvcpk_out_if.source                  out_ch
);
  import uvcpk_pkg::*;

  logic                         item_vld_r, item_vld_nxt;
  logic [7:0]                   item_byte_r;
  logic                         len_sent_r, len_sent_nxt;
  logic [POSITION_BITS-1:0]     pos_r, pos_nxt;
  logic [PACKET_COUNT_BITS-1:0] pkt_rem_r, pkt_rem_nxt;
  logic                         frame_id_r, frame_id_nxt;

  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_hdr_r, out_hdr_nxt;
  logic       out_pend_r, out_pend_nxt;
  logic       out_fend_r, out_fend_nxt;

  logic                   out_free, emit, open_pkt, data_go, in_take;
  logic [POSITION_BITS:0] pos_ext, left;
  logic                   fits, fend, pend;

  assign out_free = !out_vld_r || out_ch.ready;
  assign emit     = item_vld_r && out_free;
  assign open_pkt = (pkt_rem_r == '0);
  assign data_go  = emit && !open_pkt;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !item_vld_r || data_go;

  always_comb begin
    pos_ext = {1'b0, pos_r};
    left    = (pos_ext < frame_len) ? (frame_len - pos_ext) : (POSITION_BITS+1)'(1);
    fits    = (left <= (POSITION_BITS+1)'(capacity));
    fend    = (left == (POSITION_BITS+1)'(1));
    pend    = fend || (pkt_rem_r == PACKET_COUNT_BITS'(1));
  end

  always_comb begin
    item_vld_nxt = item_vld_r;
    len_sent_nxt = len_sent_r;
    pos_nxt      = pos_r;
    pkt_rem_nxt  = pkt_rem_r;
    frame_id_nxt = frame_id_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_byte_nxt = out_byte_r;
    out_hdr_nxt  = out_hdr_r;
    out_pend_nxt = out_pend_r;
    out_fend_nxt = out_fend_r;

    if (emit) begin
      out_vld_nxt = 1'b1;
      if (open_pkt && !len_sent_r) begin
        out_byte_nxt = HDR_LEN;
        out_hdr_nxt  = 1'b1;
        out_pend_nxt = 1'b0;
        out_fend_nxt = 1'b0;
        len_sent_nxt = 1'b1;
      end else if (open_pkt) begin
        out_byte_nxt = FLAG_EOH | (fits ? FLAG_EOF : 8'h00) | {7'd0, frame_id_r};
        out_hdr_nxt  = 1'b1;
        out_pend_nxt = 1'b0;
        out_fend_nxt = 1'b0;
        len_sent_nxt = 1'b0;
        pkt_rem_nxt  = fits ? left[PACKET_COUNT_BITS-1:0] : capacity;
      end else begin
        out_byte_nxt = item_byte_r;
        out_hdr_nxt  = 1'b0;
        out_pend_nxt = pend;
        out_fend_nxt = fend;
        item_vld_nxt = 1'b0;
        if (fend) begin
          pos_nxt      = '0;
          pkt_rem_nxt  = '0;
          frame_id_nxt = !frame_id_r;
        end else begin
          pos_nxt     = pos_r + POSITION_BITS'(1);
          pkt_rem_nxt = pend ? '0 : (pkt_rem_r - PACKET_COUNT_BITS'(1));
        end
      end
    end

    if (in_take) begin
      item_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      len_sent_r <= 1'b0;
      pos_r      <= '0;
      pkt_rem_r  <= '0;
      frame_id_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      len_sent_r <= len_sent_nxt;
      pos_r      <= pos_nxt;
      pkt_rem_r  <= pkt_rem_nxt;
      frame_id_r <= frame_id_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_byte_r <= in_ch.pixel_byte;
    end
    out_byte_r <= out_byte_nxt;
    out_hdr_r  <= out_hdr_nxt;
    out_pend_r <= out_pend_nxt;
    out_fend_r <= out_fend_nxt;
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.is_header  = out_hdr_r;
  assign out_ch.packet_end = out_pend_r;
  assign out_ch.frame_end  = out_fend_r;

endmodule
